FILE: rtl/nwm_pkg.sv
// Package for the nth-weekday-of-month block: item types, codes and
// small calendar helper functions. Depends on nothing.
package nwm_pkg;

    // Field widths fixed by the item formats.
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WDAY_W  = 3;
    localparam int ACT_W   = 3;
    localparam int DAY_W   = 5;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Adjusted year (year + 400, -1 before March), day-count sum widths.
    localparam int YADJ_W = 15;
    localparam int SUM_W  = 15;
    localparam int Q100_W = 8;
    localparam int PROD_W = 28;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690.
    localparam logic [PROD_W-1:0] DIV100_MUL = PROD_W'(5243);
    localparam int DIV100_SHIFT = 19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MONTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_YEAR  = CFG_IDX_W'(1);

    // Reset values of the configuration registers.
    localparam logic [MONTH_W-1:0] MONTH_RESET = MONTH_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = YEAR_W'(2000);

    // Rule codes.
    localparam logic [ACT_W-1:0] ACT_TEENTH = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_FIRST  = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_FIFTH  = ACT_W'(5);
    localparam logic [ACT_W-1:0] ACT_LAST   = ACT_W'(6);

    // Weekday limit: Saturday.
    localparam logic [WDAY_W-1:0] WDAY_SAT = WDAY_W'(6);

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_RANGE = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_NONE  = STAT_W'(2);

    typedef struct packed {
        logic [WDAY_W-1:0] weekday;
        logic [ACT_W-1:0]  action;
    } nwm_query_t;

    typedef struct packed {
        logic [DAY_W-1:0]  day_of_month;
        logic [STAT_W-1:0] status;
    } nwm_result_t;

    // Calendar facts of the month travelling with each item.
    typedef struct packed {
        logic              month_ok;
        logic [2:0]        first_wday;
        logic [DAY_W-1:0]  days;
        logic [WDAY_W-1:0] weekday;
        logic [ACT_W-1:0]  action;
    } nwm_cal_t;

    // Remainder modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [SUM_W-1:0] v);
        logic [5:0] s;
        logic [3:0] t;
        s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
        t = 4'(s[2:0]) + 4'(s[5:3]);
        if (t >= 4'd7)
        begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

    // Day offsets of the months for the weekday formula.
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Number of days in a month.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
            4'd2:                    r = leap ? DAY_W'(29) : DAY_W'(28);
            default:                 r = DAY_W'(31);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/nwm_cal.sv
// Calendar pipeline: four register stages that find the weekday of the
// first of the month and the month length. Depends on nwm_pkg.
module nwm_cal
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_stall,
    input  nwm_pkg::nwm_query_t           up_item,
    input  logic [nwm_pkg::MONTH_W-1:0]   month,
    input  logic [nwm_pkg::YEAR_W-1:0]    year,
    output logic                          dn_valid,
    input  logic                          dn_stall,
    output nwm_pkg::nwm_cal_t             dn_item
);

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // Stage 1: item, month and adjusted year.
    nwm_pkg::nwm_query_t               q1_reg;
    logic [nwm_pkg::MONTH_W-1:0]       m1_reg;
    logic [nwm_pkg::YEAR_W-1:0]        yr1_reg;
    logic [nwm_pkg::YADJ_W-1:0]        y1_reg;
    logic [nwm_pkg::YADJ_W-1:0]        y1_next;

    // Stage 2: centuries of the adjusted year and of the year itself.
    nwm_pkg::nwm_query_t               q2_reg;
    logic [nwm_pkg::MONTH_W-1:0]       m2_reg;
    logic [nwm_pkg::YEAR_W-1:0]        yr2_reg;
    logic [nwm_pkg::YADJ_W-1:0]        y2_reg;
    logic [nwm_pkg::Q100_W-1:0]        c2_reg;
    logic [nwm_pkg::Q100_W-1:0]        c2_next;
    logic [nwm_pkg::Q100_W-1:0]        cy2_reg;
    logic [nwm_pkg::Q100_W-1:0]        cy2_next;
    logic [nwm_pkg::PROD_W-1:0]        prod_y;
    logic [nwm_pkg::PROD_W-1:0]        prod_yr;

    // Stage 3: weekday sum and month length.
    nwm_pkg::nwm_query_t               q3_reg;
    logic                              ok3_reg;
    logic [nwm_pkg::SUM_W-1:0]         sum3_reg;
    logic [nwm_pkg::SUM_W-1:0]         sum3_next;
    logic [nwm_pkg::DAY_W-1:0]         dim3_reg;
    logic [nwm_pkg::DAY_W-1:0]         dim3_next;
    logic [nwm_pkg::YEAR_W-1:0]        rem100;
    logic                              leap;

    // Stage 4: weekday of the first.
    nwm_pkg::nwm_cal_t                 c4_reg;
    nwm_pkg::nwm_cal_t                 c4_next;

    // A stage loads when it is empty or its contents move on.
    assign adv4     = !v4_reg || !dn_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign up_stall = !adv1;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= up_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // January and February count in the previous year; a whole
    // 400-year cycle is added so the year never goes negative.
    always_comb
    begin
        y1_next = nwm_pkg::YADJ_W'(year) + nwm_pkg::YADJ_W'(400)
                  - ((month < nwm_pkg::MONTH_W'(3)) ? nwm_pkg::YADJ_W'(1)
                                                    : nwm_pkg::YADJ_W'(0));
    end

    // Division by 100 through a reciprocal multiply.
    always_comb
    begin
        prod_y   = nwm_pkg::PROD_W'(y1_reg) * nwm_pkg::DIV100_MUL;
        prod_yr  = nwm_pkg::PROD_W'(yr1_reg) * nwm_pkg::DIV100_MUL;
        c2_next  = prod_y[nwm_pkg::DIV100_SHIFT +: nwm_pkg::Q100_W];
        cy2_next = prod_yr[nwm_pkg::DIV100_SHIFT +: nwm_pkg::Q100_W];
    end

    // Weekday sum y + y/4 - y/100 + y/400 + offset + 1, and the leap rule.
    always_comb
    begin
        sum3_next = y2_reg + (y2_reg >> 2)
                    - nwm_pkg::SUM_W'(c2_reg) + nwm_pkg::SUM_W'(c2_reg >> 2)
                    + nwm_pkg::SUM_W'(nwm_pkg::month_offset(m2_reg))
                    + nwm_pkg::SUM_W'(1);
        rem100    = yr2_reg - nwm_pkg::YEAR_W'(cy2_reg) * nwm_pkg::YEAR_W'(100);
        leap      = ((yr2_reg[1:0] == 2'b00) && (rem100 != '0))
                    || ((rem100 == '0) && (cy2_reg[1:0] == 2'b00));
        dim3_next = nwm_pkg::month_days(m2_reg, leap);
    end

    // Reduce the sum to a weekday.
    always_comb
    begin
        c4_next.month_ok   = ok3_reg;
        c4_next.first_wday = nwm_pkg::mod7(sum3_reg);
        c4_next.days       = dim3_reg;
        c4_next.weekday    = q3_reg.weekday;
        c4_next.action     = q3_reg.action;
    end

    // Stage data registers.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            q1_reg  <= up_item;
            m1_reg  <= month;
            yr1_reg <= year;
            y1_reg  <= y1_next;
        end
        if (adv2)
        begin
            q2_reg  <= q1_reg;
            m2_reg  <= m1_reg;
            yr2_reg <= yr1_reg;
            y2_reg  <= y1_reg;
            c2_reg  <= c2_next;
            cy2_reg <= cy2_next;
        end
        if (adv3)
        begin
            q3_reg   <= q2_reg;
            ok3_reg  <= (m2_reg >= nwm_pkg::MONTH_W'(1))
                        && (m2_reg <= nwm_pkg::MONTH_W'(12));
            sum3_reg <= sum3_next;
            dim3_reg <= dim3_next;
        end
        if (adv4)
        begin
            c4_reg <= c4_next;
        end
    end

    assign dn_valid = v4_reg;
    assign dn_item  = c4_reg;

endmodule

FILE: rtl/nwm_pick.sv
// Rule stage: applies the query rule to the month's calendar facts and
// holds the result in the output register. Depends on nwm_pkg.
module nwm_pick
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_stall,
    input  nwm_pkg::nwm_cal_t    up_item,
    output logic                 dn_valid,
    input  logic                 dn_stall,
    output nwm_pkg::nwm_result_t dn_item
);

    logic                        valid_reg;
    nwm_pkg::nwm_result_t        res_reg;
    nwm_pkg::nwm_result_t        res_next;
    logic                        adv;

    logic [nwm_pkg::SUM_W-1:0]   t;
    logic [nwm_pkg::SUM_W-1:0]   w1;
    logic [nwm_pkg::SUM_W-1:0]   dim;
    logic [2:0]                  first_off;
    logic [2:0]                  w13;
    logic [2:0]                  wl;
    logic [5:0]                  nth_day;
    logic [nwm_pkg::DAY_W-1:0]   teen_day;
    logic [nwm_pkg::DAY_W-1:0]   last_day;

    assign adv      = !valid_reg || !dn_stall;
    assign up_stall = !adv;

    // Candidate days for each rule.
    always_comb
    begin
        t         = nwm_pkg::SUM_W'(up_item.weekday);
        w1        = nwm_pkg::SUM_W'(up_item.first_wday);
        dim       = nwm_pkg::SUM_W'(up_item.days);
        first_off = nwm_pkg::mod7(t + nwm_pkg::SUM_W'(7) - w1);
        w13       = nwm_pkg::mod7(w1 + nwm_pkg::SUM_W'(12));
        wl        = nwm_pkg::mod7(w1 + dim - nwm_pkg::SUM_W'(1));
        teen_day  = nwm_pkg::DAY_W'(13) + nwm_pkg::DAY_W'(
                        nwm_pkg::mod7(t + nwm_pkg::SUM_W'(7) - nwm_pkg::SUM_W'(w13)));
        last_day  = up_item.days - nwm_pkg::DAY_W'(
                        nwm_pkg::mod7(nwm_pkg::SUM_W'(wl) + nwm_pkg::SUM_W'(7) - t));
        nth_day   = 6'd1 + 6'(first_off)
                    + 6'd7 * 6'(up_item.action - nwm_pkg::ACT_FIRST);
    end

    // Select the rule and the status.
    always_comb
    begin
        res_next.day_of_month = '0;
        res_next.status       = nwm_pkg::ST_NONE;
        if (!up_item.month_ok)
        begin
            res_next.status = nwm_pkg::ST_RANGE;
        end
        else if (up_item.weekday <= nwm_pkg::WDAY_SAT)
        begin
            if (up_item.action == nwm_pkg::ACT_TEENTH)
            begin
                res_next.day_of_month = teen_day;
                res_next.status       = nwm_pkg::ST_OK;
            end
            else if (up_item.action <= nwm_pkg::ACT_FIFTH)
            begin
                if (nth_day <= 6'(up_item.days))
                begin
                    res_next.day_of_month = nth_day[nwm_pkg::DAY_W-1:0];
                    res_next.status       = nwm_pkg::ST_OK;
                end
            end
            else if (up_item.action == nwm_pkg::ACT_LAST)
            begin
                res_next.day_of_month = last_day;
                res_next.status       = nwm_pkg::ST_OK;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = res_reg;

endmodule

FILE: rtl/nth_weekday_of_month.sv
// Top level of the nth-weekday-of-month block: configuration registers,
// calendar pipeline and rule stage. Depends on nwm_pkg, nwm_cal, nwm_pick.
//
// Usage:
//   cal_month and cal_year are written through the cfg channel (index 0 and
//   1, cfg_ready is always high; other indexes are ignored). Write them only
//   while no item is in flight.
//   Each query item carries a weekday (0 Sunday .. 6 Saturday) and an
//   action (0 teenth, 1..5 first..fifth, 6 last). Each query gives exactly
//   one result item with day_of_month and status.
//   Pipeline: a result passes through five register stages (year adjust,
//   divide by 100, weekday sum and month length, modulo 7, rule select and
//   output register).
//   Throughput: one item per cycle while no stall holds the pipeline.
//   Stall: when result_stall holds a waiting result, earlier stages keep
//   filling their empty slots; query_stall rises only once every stage
//   holds an item.
//   Reset: all stages are emptied, cal_month returns to 1 and cal_year to
//   2000.
module nth_weekday_of_month
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            query_valid,
    output logic                            query_stall,
    input  nwm_pkg::nwm_query_t             query,
    output logic                            result_valid,
    input  logic                            result_stall,
    output nwm_pkg::nwm_result_t            result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nwm_pkg::YEAR_W-1:0]      cfg_data
);

    logic [nwm_pkg::MONTH_W-1:0] cal_month_reg;
    logic [nwm_pkg::YEAR_W-1:0]  cal_year_reg;

    logic                        cal_valid;
    logic                        cal_stall;
    nwm_pkg::nwm_cal_t           cal_item;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_month_reg <= nwm_pkg::MONTH_RESET;
            cal_year_reg  <= nwm_pkg::YEAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nwm_pkg::REG_MONTH: cal_month_reg <= cfg_data[nwm_pkg::MONTH_W-1:0];
                nwm_pkg::REG_YEAR:  cal_year_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Calendar pipeline.
    nwm_cal u_cal
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (query_valid),
        .up_stall (query_stall),
        .up_item  (query),
        .month    (cal_month_reg),
        .year     (cal_year_reg),
        .dn_valid (cal_valid),
        .dn_stall (cal_stall),
        .dn_item  (cal_item)
    );

    // Rule stage and output register.
    nwm_pick u_pick
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cal_valid),
        .up_stall (cal_stall),
        .up_item  (cal_item),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .dn_item  (result)
    );

    // A successful result always names a real day.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == nwm_pkg::ST_OK) |-> (result.day_of_month != '0))
    else $error("successful result with day zero");

    // A failed result always carries day zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != nwm_pkg::ST_OK) |-> (result.day_of_month == '0))
    else $error("failed result with nonzero day");

    // With the output register empty the whole pipeline can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !query_stall)
    else $error("query stalled while the output register is empty");

endmodule

FILE: test/nth_weekday_of_month_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nth_weekday_of_month: directed calendar cases,
// then random months, years and queries under random idling on both sides.
// Depends on nwm_pkg and the nth_weekday_of_month RTL.
module nth_weekday_of_month_tb;

    localparam int RESULT_LATENCY = 5;
    localparam int RANDOM_QUERIES = 1350;
    localparam int LIMIT_CYCLES   = 200000;

    // Codes the package leaves unnamed.
    localparam logic [nwm_pkg::ACT_W-1:0]  ACT_SECOND = nwm_pkg::ACT_W'(2);
    localparam logic [nwm_pkg::ACT_W-1:0]  ACT_THIRD  = nwm_pkg::ACT_W'(3);
    localparam logic [nwm_pkg::ACT_W-1:0]  ACT_FOURTH = nwm_pkg::ACT_W'(4);
    localparam logic [nwm_pkg::ACT_W-1:0]  ACT_BAD    = nwm_pkg::ACT_W'(7);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_SUN   = nwm_pkg::WDAY_W'(0);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_MON   = nwm_pkg::WDAY_W'(1);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_TUE   = nwm_pkg::WDAY_W'(2);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_WED   = nwm_pkg::WDAY_W'(3);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_THU   = nwm_pkg::WDAY_W'(4);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_FRI   = nwm_pkg::WDAY_W'(5);
    localparam logic [nwm_pkg::WDAY_W-1:0] WDAY_BAD   = nwm_pkg::WDAY_W'(7);
    localparam logic [nwm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = nwm_pkg::CFG_IDX_W'(2);
    localparam logic [nwm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = nwm_pkg::CFG_IDX_W'(3);

    // Receiver stall patterns.
    localparam int STALL_OFF      = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    typedef struct {
        logic [nwm_pkg::MONTH_W-1:0] month;
        logic [nwm_pkg::YEAR_W-1:0]  year;
        nwm_pkg::nwm_query_t         q;
        bit                          typed;
        nwm_pkg::nwm_result_t        want;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          query_valid = 1'b0;
    logic                          query_stall;
    nwm_pkg::nwm_query_t           query = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    nwm_pkg::nwm_result_t          result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [nwm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nwm_pkg::YEAR_W-1:0]    cfg_data = '0;

    // Calendar registers as the block should hold them.
    logic [nwm_pkg::MONTH_W-1:0] cal_month_m = nwm_pkg::MONTH_RESET;
    logic [nwm_pkg::YEAR_W-1:0]  cal_year_m  = nwm_pkg::YEAR_RESET;

    nwm_pkg::nwm_result_t pending_days[$];
    plan_row_t            plan[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned found_seen     = 0;
    int unsigned range_seen     = 0;
    int unsigned missing_seen   = 0;
    int unsigned settings_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    int          stall_mode     = STALL_OFF;
    int unsigned stall_span     = 0;

    nth_weekday_of_month u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Month length without a lookup: odd months to July and even months from
    // August have 31 days.
    function automatic int unsigned month_length(input int unsigned m, input bit leap);
        if (m == 2)
        begin
            return leap ? 29 : 28;
        end
        return 30 + ((m + m / 8) % 2);
    endfunction

    // Walks the month day by day and picks the day that the rule asks for.
    function automatic nwm_pkg::nwm_result_t predict_day(
            input logic [nwm_pkg::MONTH_W-1:0] month,
            input logic [nwm_pkg::YEAR_W-1:0] year,
            input nwm_pkg::nwm_query_t q);
        nwm_pkg::nwm_result_t r;
        int unsigned y;
        int unsigned lead;
        int unsigned dim;
        int unsigned wday_first;
        int unsigned hits;
        int unsigned last_hit;
        int unsigned teen_hit;
        int unsigned nth_hit;
        int unsigned chosen;
        bit          leap;
        r.day_of_month = '0;
        r.status = nwm_pkg::ST_NONE;
        if (month < 1 || month > 12)
        begin
            r.status = nwm_pkg::ST_RANGE;
            return r;
        end
        y = year;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        // Days from 1 January of year 0, which fell on a Saturday.
        lead = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int unsigned m = 1; m < month; m++)
        begin
            lead += month_length(m, leap);
        end
        wday_first = (6 + lead) % 7;
        dim = month_length(month, leap);
        hits = 0;
        last_hit = 0;
        teen_hit = 0;
        nth_hit = 0;
        for (int unsigned d = 1; d <= dim; d++)
        begin
            if ((wday_first + d - 1) % 7 == q.weekday)
            begin
                hits++;
                last_hit = d;
                if (hits == q.action)
                begin
                    nth_hit = d;
                end
                if (d >= 13 && d <= 19)
                begin
                    teen_hit = d;
                end
            end
        end
        case (q.action)
            nwm_pkg::ACT_TEENTH: chosen = teen_hit;
            nwm_pkg::ACT_LAST:   chosen = last_hit;
            ACT_BAD:             chosen = 0;
            default:             chosen = nth_hit;
        endcase
        if (chosen != 0)
        begin
            r.day_of_month = nwm_pkg::DAY_W'(chosen);
            r.status = nwm_pkg::ST_OK;
        end
        return r;
    endfunction

    function automatic plan_row_t plan_entry(input int unsigned month, input int unsigned year,
                                             input logic [nwm_pkg::WDAY_W-1:0] wd,
                                             input logic [nwm_pkg::ACT_W-1:0] act,
                                             input bit typed, input int unsigned day,
                                             input logic [nwm_pkg::STAT_W-1:0] st);
        plan_row_t p;
        p.month = nwm_pkg::MONTH_W'(month);
        p.year = nwm_pkg::YEAR_W'(year);
        p.q.weekday = wd;
        p.q.action = act;
        p.typed = typed;
        p.want.day_of_month = nwm_pkg::DAY_W'(day);
        p.want.status = st;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Waits until the pipeline is empty so the registers may change.
    task automatic drain;
        query_valid <= 1'b0;
        while (pending_days.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [nwm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nwm_pkg::YEAR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            nwm_pkg::REG_MONTH: cal_month_m = data[nwm_pkg::MONTH_W-1:0];
            nwm_pkg::REG_YEAR:  cal_year_m = data;
            default:            ;
        endcase
    endtask

    // Moves to a new month, with junk in the unused upper bits of the month
    // write and now and then a write to an unused index.
    task automatic set_calendar(input logic [nwm_pkg::MONTH_W-1:0] month,
                                input logic [nwm_pkg::YEAR_W-1:0] year);
        logic [nwm_pkg::YEAR_W-nwm_pkg::MONTH_W-1:0] junk;
        drain();
        junk = ($urandom_range(0, 1) == 0) ? '0
               : (nwm_pkg::YEAR_W - nwm_pkg::MONTH_W)'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      nwm_pkg::YEAR_W'($urandom));
        end
        write_reg(nwm_pkg::REG_MONTH, {junk, month});
        write_reg(nwm_pkg::REG_YEAR, year);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Offers one query, idling between bursts, and records what it must give.
    task automatic send_query(input nwm_pkg::nwm_query_t q, input bit typed,
                              input nwm_pkg::nwm_result_t want);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                query_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        query <= q;
        query_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (query_stall);
        pending_days.push_back(typed ? want : predict_day(cal_month_m, cal_year_m, q));
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        nwm_pkg::nwm_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_days.size() == 0)
            begin
                report_mismatch("result with no query pending, day", result.day_of_month, 0);
            end
            else
            begin
                want = pending_days.pop_front();
                if (result.day_of_month !== want.day_of_month)
                begin
                    report_mismatch("day_of_month", result.day_of_month, want.day_of_month);
                end
                if (result.status !== want.status)
                begin
                    report_mismatch("status", result.status, want.status);
                end
            end
            case (result.status)
                nwm_pkg::ST_OK:    found_seen++;
                nwm_pkg::ST_RANGE: range_seen++;
                default:           missing_seen++;
            endcase
        end
    end

    // Receiver stall, switching pattern every so often.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(STALL_OFF, STALL_PERIODIC);
            stall_span <= $urandom_range(16, 160);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: result_stall <= (cycle_count[3:2] == 2'b11);
            default:        result_stall <= 1'b0;
        endcase
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("nth_weekday_of_month_tb failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned                 random_sent;
        int unsigned                 phase_len;
        int unsigned                 pick;
        logic [nwm_pkg::MONTH_W-1:0] month;
        logic [nwm_pkg::YEAR_W-1:0]  year;
        nwm_pkg::nwm_query_t         q;
        nwm_pkg::nwm_result_t        none_want;

        none_want = '0;

        // Directed cases; the first rows use the reset calendar, January 2000.
        plan.push_back(plan_entry(1, 2000, nwm_pkg::WDAY_SAT, nwm_pkg::ACT_FIRST, 1, 1,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(1, 2000, nwm_pkg::WDAY_SAT, nwm_pkg::ACT_LAST, 1, 29,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(1, 2000, nwm_pkg::WDAY_SAT, nwm_pkg::ACT_TEENTH, 1, 15,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(1, 2000, WDAY_SUN, nwm_pkg::ACT_FIFTH, 1, 30,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(1, 2000, WDAY_BAD, nwm_pkg::ACT_FIRST, 1, 0,
                                  nwm_pkg::ST_NONE));
        plan.push_back(plan_entry(1, 2000, WDAY_WED, ACT_BAD, 1, 0, nwm_pkg::ST_NONE));
        plan.push_back(plan_entry(2, 2000, WDAY_TUE, nwm_pkg::ACT_FIFTH, 1, 29,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(2, 2001, WDAY_THU, nwm_pkg::ACT_FIFTH, 1, 0,
                                  nwm_pkg::ST_NONE));
        plan.push_back(plan_entry(2, 1900, WDAY_WED, nwm_pkg::ACT_LAST, 1, 28,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(0, 2000, WDAY_SUN, nwm_pkg::ACT_FIRST, 1, 0,
                                  nwm_pkg::ST_RANGE));
        plan.push_back(plan_entry(13, 2000, nwm_pkg::WDAY_SAT, nwm_pkg::ACT_LAST, 1, 0,
                                  nwm_pkg::ST_RANGE));
        plan.push_back(plan_entry(15, 2000, WDAY_BAD, ACT_BAD, 1, 0, nwm_pkg::ST_RANGE));
        plan.push_back(plan_entry(12, 0, WDAY_SUN, nwm_pkg::ACT_TEENTH, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(12, 0, WDAY_FRI, nwm_pkg::ACT_LAST, 0, 0, nwm_pkg::ST_OK));
        plan.push_back(plan_entry(3, 0, WDAY_MON, ACT_SECOND, 0, 0, nwm_pkg::ST_OK));
        plan.push_back(plan_entry(2, 0, nwm_pkg::WDAY_SAT, nwm_pkg::ACT_FIFTH, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(2, 16383, nwm_pkg::WDAY_SAT, nwm_pkg::ACT_LAST, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(1, 16383, WDAY_SUN, nwm_pkg::ACT_FIFTH, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(12, 16383, nwm_pkg::WDAY_SAT, ACT_FOURTH, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(12, 9999, WDAY_FRI, nwm_pkg::ACT_LAST, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(1, 1400, WDAY_WED, ACT_THIRD, 0, 0, nwm_pkg::ST_OK));
        plan.push_back(plan_entry(2, 2100, WDAY_MON, nwm_pkg::ACT_LAST, 0, 0,
                                  nwm_pkg::ST_OK));
        plan.push_back(plan_entry(2, 2100, WDAY_MON, nwm_pkg::ACT_FIFTH, 0, 0,
                                  nwm_pkg::ST_OK));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].month != cal_month_m || plan[k].year != cal_year_m)
            begin
                set_calendar(plan[k].month, plan[k].year);
            end
            send_query(plan[k].q, plan[k].typed, plan[k].want);
        end

        // Random phases: a new calendar, then a run of queries against it.
        random_sent = 0;
        while (random_sent < RANDOM_QUERIES)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                month = nwm_pkg::MONTH_W'($urandom_range(1, 12));
            end
            else
            begin
                pick = $urandom_range(13, 16);
                month = (pick == 16) ? '0 : nwm_pkg::MONTH_W'(pick);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       year = nwm_pkg::YEAR_W'(0);
                    1:       year = nwm_pkg::YEAR_W'(16383);
                    2:       year = nwm_pkg::YEAR_W'(1400);
                    default: year = nwm_pkg::YEAR_W'(9999);
                endcase
            end
            else if (pick == 1)
            begin
                year = nwm_pkg::YEAR_W'($urandom_range(0, 16383));
            end
            else
            begin
                year = nwm_pkg::YEAR_W'($urandom_range(1400, 9999));
            end
            set_calendar(month, year);

            phase_len = $urandom_range(8, 48);
            for (int unsigned i = 0; i < phase_len; i++)
            begin
                q.weekday = ($urandom_range(0, 9) < 9)
                            ? nwm_pkg::WDAY_W'($urandom_range(0, 6)) : WDAY_BAD;
                q.action = nwm_pkg::ACT_W'($urandom_range(0, 7));
                send_query(q, 1'b0, none_want);
                random_sent++;
            end
        end

        // Let the last results come out and make sure nothing extra follows.
        query_valid <= 1'b0;
        while (pending_days.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (RESULT_LATENCY + 4) @(posedge clk);

        $display("checked %0d results over %0d calendar settings after reset",
                 results_seen, settings_count);
        $display("%0d days found, %0d months out of range, %0d days missing",
                 found_seen, range_seen, missing_seen);
        if (mismatch_count == 0)
        begin
            $display("nth_weekday_of_month_tb passed");
        end
        else
        begin
            $display("nth_weekday_of_month_tb failed");
        end
        $finish;
    end

endmodule
